// ===== rtl/info_frame_stuffing_framer_unit_defines.svh =====
// Assertion macros for the framer unit.
`ifndef INFO_FRAME_STUFFING_FRAMER_UNIT_DEFINES_SVH
`define INFO_FRAME_STUFFING_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define IFSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define IFSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ifsf_pkg.sv =====
package ifsf_pkg;

  localparam logic [7:0] FLAG_BYTE     = 8'h7E;
  localparam logic [7:0] ESC_BYTE      = 8'h7D;
  localparam logic [7:0] ESC_FLAG_BYTE = 8'h5E;
  localparam logic [7:0] ESC_ESC_BYTE  = 8'h5D;
  localparam logic [7:0] CTRL_ONE_BYTE = 8'h40;
  localparam logic [7:0] CTRL_ZERO_BYTE = 8'h00;
  localparam logic [7:0] ADDR_RESET    = 8'h03;

  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  // One queued payload request, fully classified by the front end.
  typedef struct packed {
    logic       need_hdr;  // first byte of a frame: send header first
    logic       seq;       // sequence bit for the control byte
    logic [7:0] addr;      // address byte snapshot
    logic [7:0] data;      // payload byte
    logic       last;      // closes the frame
    logic [7:0] bcc;       // BCC2, valid when last is set
  } job_t;

  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_BCC1,
    PH_DATA,
    PH_DATA_ESC,
    PH_BCC2,
    PH_BCC2_ESC,
    PH_CLOSE
  } phase_t;

  function automatic logic needs_esc(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] esc_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG_BYTE : ESC_ESC_BYTE;
  endfunction

  function automatic logic [7:0] ctrl_byte(input logic seq);
    return seq ? CTRL_ONE_BYTE : CTRL_ZERO_BYTE;
  endfunction

endpackage

// ===== rtl/ifsf_front.sv =====
module ifsf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  input  logic [7:0]        addr,
  input  logic              q_full,
  output logic              push,
  output ifsf_pkg::job_t    push_job
);
  import ifsf_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] chk_r, chk_nxt;
  logic       seq_r, seq_nxt;
  logic       accept;
  logic [7:0] chk_new;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign chk_new  = (in_frame_r ? chk_r : 8'h00) ^ in_data_byte;

  always_comb begin
    in_frame_nxt = in_frame_r;
    chk_nxt      = chk_r;
    seq_nxt      = seq_r;
    push         = 1'b0;
    push_job.need_hdr = !in_frame_r;
    push_job.seq      = seq_r;
    push_job.addr     = addr;
    push_job.data     = in_data_byte;
    push_job.last     = in_last_byte;
    push_job.bcc      = chk_new;
    if (accept) begin
      if (in_cmd == CMD_ACK) begin
        seq_nxt = !seq_r;
      end else begin
        push         = 1'b1;
        in_frame_nxt = !in_last_byte;
        chk_nxt      = in_last_byte ? 8'h00 : chk_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      chk_r      <= 8'h00;
      seq_r      <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      chk_r      <= chk_nxt;
      seq_r      <= seq_nxt;
    end
  end

endmodule

// ===== rtl/ifsf_queue.sv =====
module ifsf_queue #(
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  ifsf_pkg::job_t               push_job,
  input  logic                         pop,
  output ifsf_pkg::job_t               head,
  output logic                         full,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import ifsf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  job_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== rtl/ifsf_back.sv =====
module ifsf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ifsf_pkg::job_t  head,
  input  logic            q_empty,
  output logic            pop,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_end_of_run,
  output logic            out_end_of_frame
);
  import ifsf_pkg::*;

  job_t       job_r, job_nxt;
  phase_t     phase_r, phase_nxt;
  logic       busy_r, busy_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       eor_r, eor_nxt;
  logic       eof_r, eof_nxt;
  logic       emit, fin, load;
  logic [7:0] cur_byte;
  logic       cur_eof;
  phase_t     step_phase;

  assign emit = busy_r && (!ov_r || out_ready);

  // Byte for the current phase and the phase after it.
  always_comb begin
    cur_byte   = FLAG_BYTE;
    cur_eof    = 1'b0;
    fin        = 1'b0;
    step_phase = phase_r;
    unique case (phase_r)
      PH_FLAG: begin
        cur_byte   = FLAG_BYTE;
        step_phase = PH_ADDR;
      end
      PH_ADDR: begin
        cur_byte   = job_r.addr;
        step_phase = PH_CTRL;
      end
      PH_CTRL: begin
        cur_byte   = ctrl_byte(job_r.seq);
        step_phase = PH_BCC1;
      end
      PH_BCC1: begin
        cur_byte   = job_r.addr ^ ctrl_byte(job_r.seq);
        step_phase = PH_DATA;
      end
      PH_DATA: begin
        if (needs_esc(job_r.data)) begin
          cur_byte   = ESC_BYTE;
          step_phase = PH_DATA_ESC;
        end else begin
          cur_byte   = job_r.data;
          step_phase = PH_BCC2;
          fin        = !job_r.last;
        end
      end
      PH_DATA_ESC: begin
        cur_byte   = esc_code(job_r.data);
        step_phase = PH_BCC2;
        fin        = !job_r.last;
      end
      PH_BCC2: begin
        if (needs_esc(job_r.bcc)) begin
          cur_byte   = ESC_BYTE;
          step_phase = PH_BCC2_ESC;
        end else begin
          cur_byte   = job_r.bcc;
          step_phase = PH_CLOSE;
        end
      end
      PH_BCC2_ESC: begin
        cur_byte   = esc_code(job_r.bcc);
        step_phase = PH_CLOSE;
      end
      PH_CLOSE: begin
        cur_byte = FLAG_BYTE;
        cur_eof  = 1'b1;
        fin      = 1'b1;
      end
      default: begin
        cur_byte = FLAG_BYTE;
        fin      = 1'b1;
      end
    endcase
  end

  always_comb begin
    load      = (!busy_r || (emit && fin)) && !q_empty;
    job_nxt   = load ? head : job_r;
    phase_nxt = phase_r;
    busy_nxt  = busy_r;
    if (load) begin
      busy_nxt  = 1'b1;
      phase_nxt = head.need_hdr ? PH_FLAG : PH_DATA;
    end else if (emit) begin
      busy_nxt  = !fin;
      phase_nxt = step_phase;
    end
    ov_nxt  = emit ? 1'b1 : (out_ready ? 1'b0 : ov_r);
    ob_nxt  = emit ? cur_byte : ob_r;
    eor_nxt = emit ? fin : eor_r;
    eof_nxt = emit ? cur_eof : eof_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_FLAG;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ob_r  <= ob_nxt;
    eor_r <= eor_nxt;
    eof_r <= eof_nxt;
  end

  assign pop              = load;
  assign busy             = busy_r;
  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_end_of_run   = eor_r;
  assign out_end_of_frame = eof_r;

endmodule

// ===== rtl/info_frame_stuffing_framer_unit.sv =====
// Channel | Direction | Ports
// in      | input     | in_valid/in_ready, in_cmd, in_data_byte, in_last_byte
// out     | output    | out_valid/out_ready, out_byte, out_end_of_run, out_end_of_frame
// cfg     | input     | cfg_valid/cfg_ready, cfg_address_byte (always ready)
//
// One output byte per cycle from the back-end sequencer unless out_ready stalls it;
// a payload request sends a header first when it opens a frame, its data byte (stuffed
// if needed), and BCC2 plus flag when it closes the frame. Acks skip the back end.
// in_ready drops only when the request queue is full; out_ready stalls the back end.
// rst_n is synchronous: no frame open, sequence 0, address 0x03.
`include "info_frame_stuffing_framer_unit_defines.svh"

module info_frame_stuffing_framer_unit #(
  parameter int QUEUE_DEPTH = 2   // 2..32 queued payload requests
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_end_of_run,
  output logic       out_end_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_address_byte
);
  import ifsf_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Address register; the user must write it only while idle, the block does not enforce it.
  logic [7:0] addr_r, addr_nxt;

  job_t          push_job, head;
  logic          push, pop, q_full, q_empty, back_busy;
  logic [CW-1:0] q_count;

  assign cfg_ready = 1'b1;
  assign addr_nxt  = (cfg_valid && cfg_ready) ? cfg_address_byte : addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  // Front end: sequence bit, frame-open flag and BCC2 accumulation; acks stop here.
  ifsf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .addr         (addr_r),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  // Classified payload requests wait here.
  ifsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  // Back end: walks header / stuffed data / BCC2 / flag, one byte per cycle when not stalled.
  ifsf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .busy             (back_busy),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_end_of_run   (out_end_of_run),
    .out_end_of_frame (out_end_of_frame)
  );

  `IFSF_ASSERT_NOW(a_eof_is_flag, out_valid && out_end_of_frame,
    out_byte == FLAG_BYTE && out_end_of_run, "closing byte is not a final flag")
  `IFSF_ASSERT_NOW(a_q_bound, 1'b1, q_count <= CW'(QUEUE_DEPTH),
    "request queue overflow")
  `IFSF_ASSERT_NEXT(a_back_picks_up, !back_busy && !q_empty, back_busy,
    "back end idle with work queued")

endmodule
